FILE: hdl/max_flow_augmenting_path_defines.svh
// Assertion macros for the max-flow block.
// Used by the top level; needs clk and rst in scope.
`ifndef MAX_FLOW_AUGMENTING_PATH_DEFINES_SVH
`define MAX_FLOW_AUGMENTING_PATH_DEFINES_SVH

`define MF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mf_pkg.sv
// Shared constants, state type and controller/datapath bundles for the max-flow block.
// No dependencies.
`default_nettype none
package mf_pkg;
  localparam int MAX_NODES  = 16;
  localparam int MAX_ARCS   = 64;
  localparam int CAP_BITS   = 16;
  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int ARC_BITS   = $clog2(MAX_ARCS);
  localparam int PTR_BITS   = ARC_BITS + 1;
  localparam int QCNT_BITS  = NODE_BITS + 1;
  localparam int BOT_BITS   = CAP_BITS + 1;
  localparam int FLOW_BITS  = 21;
  localparam int FLOW_MAX   = 2097151;
  localparam int FIELD_NODE_W = 4;
  localparam int FIELD_CAP_W  = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_SOURCE = cfg_addr_t'(0);
  localparam cfg_addr_t REG_SINK   = cfg_addr_t'(1);

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_COMPUTE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_FWD, S_ADD_REV, S_BFS_INIT, S_POP, S_ARC_RD, S_ARC_EV,
    S_PUSH_RD, S_PUSH_FWD, S_PUSH_REV, S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_edge;
    logic add_fwd;
    logic add_rev;
    logic set_drop;
    logic bfs_init;
    logic pop;
    logic arc_rd;
    logic arc_ev;
    logic push_rd;
    logic push_fwd;
    logic push_rev;
    logic flow_add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic                edge_fits;
    logic                queue_empty;
    logic                arc_end;
    logic                found;
    logic                push_end;
    logic                out_free;
    logic [PTR_BITS-1:0] arc_cnt;
  } sts_t;
endpackage
`default_nettype wire

FILE: hdl/mf_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/mf_ctrl.sv
// Controller state machine for the max-flow block.
// Depends on mf_pkg; drives the datapath through cmd_t, reads sts_t.
`default_nettype none
module mf_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_command,
  output      logic         in_ready,
  input  wire mf_pkg::sts_t sts,
  output      mf_pkg::cmd_t cmd,
  output      mf_pkg::ctrl_state_t state
);
  import mf_pkg::*;

  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_edge = 1'b1;
          state_next = (in_command == CMD_COMPUTE) ? S_BFS_INIT : S_ADD_FWD;
        end
      end
      S_ADD_FWD: begin
        if (sts.edge_fits) begin
          cmd.add_fwd = 1'b1;
          state_next  = S_ADD_REV;
        end else begin
          cmd.set_drop = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ADD_REV: begin
        cmd.add_rev = 1'b1;
        state_next  = S_IDLE;
      end
      S_BFS_INIT: begin
        cmd.bfs_init = 1'b1;
        state_next   = S_POP;
      end
      S_POP: begin
        if (sts.queue_empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_ARC_RD;
        end
      end
      S_ARC_RD: begin
        if (sts.arc_end) begin
          state_next = S_POP;
        end else begin
          cmd.arc_rd = 1'b1;
          state_next = S_ARC_EV;
        end
      end
      S_ARC_EV: begin
        cmd.arc_ev = 1'b1;
        state_next = sts.found ? S_PUSH_RD : S_ARC_RD;
      end
      S_PUSH_RD: begin
        if (sts.push_end) begin
          cmd.flow_add = 1'b1;
          state_next   = S_BFS_INIT;
        end else begin
          cmd.push_rd = 1'b1;
          state_next  = S_PUSH_FWD;
        end
      end
      S_PUSH_FWD: begin
        cmd.push_fwd = 1'b1;
        state_next   = S_PUSH_REV;
      end
      S_PUSH_REV: begin
        cmd.push_rev = 1'b1;
        state_next   = S_PUSH_RD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/mf_datapath.sv
// Datapath for the max-flow block: arc store, adjacency heads, search queue,
// path walk and flow total. Depends on mf_pkg and mf_ram.
`default_nettype none
module mf_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire mf_pkg::cfg_addr_t               cfg_addr,
  input  wire logic [mf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [mf_pkg::IN_DATA_W-1:0]    in_data,
  input  wire mf_pkg::cmd_t                    cmd,
  output      mf_pkg::sts_t                    sts,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [mf_pkg::OUT_DATA_W-1:0]   out_data
);
  import mf_pkg::*;

  logic [NODE_BITS-1:0]  src_node, dst_node;
  logic [PTR_BITS-1:0]   list_head [MAX_NODES];
  logic [PTR_BITS-1:0]   arc_count;
  logic [MAX_NODES-1:0]  visited;
  logic [BOT_BITS-1:0]   bott [MAX_NODES];
  logic [ARC_BITS-1:0]   arrival [MAX_NODES];
  logic [NODE_BITS-1:0]  queue [MAX_NODES];
  logic [QCNT_BITS-1:0]  rd_ptr, wr_ptr;
  logic [NODE_BITS-1:0]  cur_x;
  logic [PTR_BITS-1:0]   cur_arc;
  logic [NODE_BITS-1:0]  push_x;
  logic [ARC_BITS-1:0]   push_arc;
  logic [BOT_BITS-1:0]   push_b;
  logic [QCNT_BITS-1:0]  steps;
  logic [FLOW_BITS-1:0]  flow;
  logic                  drop;
  logic [NODE_BITS-1:0]  e_from, e_to;
  logic [CAP_BITS-1:0]   e_cap;

  logic [NODE_BITS-1:0]  lh_addr, y, q_head;
  logic [PTR_BITS-1:0]   lh_rd;
  logic [BOT_BITS-1:0]   bott_x, b_new, res_ext;
  logic                  take;
  logic                  res_we, arc_we;
  logic [ARC_BITS-1:0]   waddr, raddr;
  logic [CAP_BITS-1:0]   res_wdata, res_rdata;
  logic [NODE_BITS-1:0]  tgt_wdata, tgt_rdata;
  logic [PTR_BITS-1:0]   link_rdata;
  logic [FLOW_BITS:0]    flow_sum;

  assign q_head  = queue[rd_ptr[NODE_BITS-1:0]];
  assign lh_addr = cmd.pop ? q_head : (cmd.add_rev ? e_to : e_from);
  assign lh_rd   = list_head[lh_addr];
  assign y       = tgt_rdata;
  assign bott_x  = bott[cur_x];
  assign res_ext = BOT_BITS'(res_rdata);
  assign b_new   = (res_ext < bott_x) ? res_ext : bott_x;
  assign take    = (res_rdata != '0) && !visited[y];
  assign flow_sum = (FLOW_BITS+1)'(flow) + (FLOW_BITS+1)'(push_b);

  assign sts.edge_fits   = arc_count <= PTR_BITS'(MAX_ARCS - 2);
  assign sts.queue_empty = rd_ptr == wr_ptr;
  assign sts.arc_end     = cur_arc >= arc_count;
  assign sts.found       = take && (y == dst_node);
  assign sts.push_end    = (push_x == src_node) || (steps == QCNT_BITS'(MAX_NODES));
  assign sts.out_free    = !out_valid || out_ready;
  assign sts.arc_cnt     = arc_count;

  assign arc_we = cmd.add_fwd || cmd.add_rev;
  assign res_we = arc_we || cmd.push_fwd || cmd.push_rev;

  always_comb begin
    waddr     = push_arc;
    res_wdata = res_rdata - push_b[CAP_BITS-1:0];
    tgt_wdata = e_to;
    if (cmd.add_fwd) begin
      waddr     = arc_count[ARC_BITS-1:0];
      res_wdata = e_cap;
    end else if (cmd.add_rev) begin
      waddr     = arc_count[ARC_BITS-1:0] | ARC_BITS'(1);
      res_wdata = '0;
      tgt_wdata = e_from;
    end else if (cmd.push_rev) begin
      waddr     = push_arc ^ ARC_BITS'(1);
      res_wdata = res_rdata + push_b[CAP_BITS-1:0];
    end
  end

  always_comb begin
    raddr = cur_arc[ARC_BITS-1:0];
    if (cmd.push_rd) begin
      raddr = arrival[push_x];
    end else if (cmd.push_fwd) begin
      raddr = push_arc ^ ARC_BITS'(1);
    end
  end

  mf_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_ARCS)) u_target (
    .clk(clk), .we(arc_we), .waddr(waddr), .wdata(tgt_wdata),
    .raddr(raddr), .rdata(tgt_rdata)
  );

  mf_ram #(.WIDTH(CAP_BITS), .DEPTH(MAX_ARCS)) u_residual (
    .clk(clk), .we(res_we), .waddr(waddr), .wdata(res_wdata),
    .raddr(raddr), .rdata(res_rdata)
  );

  mf_ram #(.WIDTH(PTR_BITS), .DEPTH(MAX_ARCS)) u_link (
    .clk(clk), .we(arc_we), .waddr(waddr), .wdata(lh_rd),
    .raddr(raddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      src_node  <= '0;
      dst_node  <= NODE_BITS'(1);
      arc_count <= '0;
      flow      <= '0;
      drop      <= 1'b0;
      visited   <= '0;
      out_valid <= 1'b0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      for (int n = 0; n < MAX_NODES; n++) begin
        list_head[n] <= PTR_BITS'(MAX_ARCS);
      end
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_SOURCE) begin
          src_node <= cfg_data[NODE_BITS-1:0];
        end else if (cfg_addr == REG_SINK) begin
          dst_node <= cfg_data[NODE_BITS-1:0];
        end
      end
      if (out_valid && out_ready && !cmd.emit) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_edge) begin
        e_from <= in_data[NODE_BITS-1:0];
        e_to   <= in_data[FIELD_NODE_W +: NODE_BITS];
        e_cap  <= in_data[2*FIELD_NODE_W +: CAP_BITS];
      end
      if (cmd.set_drop) begin
        drop <= 1'b1;
      end
      if (cmd.add_fwd) begin
        list_head[e_from] <= arc_count;
      end
      if (cmd.add_rev) begin
        list_head[e_to] <= arc_count | PTR_BITS'(1);
        arc_count       <= arc_count + PTR_BITS'(2);
      end
      if (cmd.bfs_init) begin
        visited         <= MAX_NODES'(1) << src_node;
        queue[0]        <= src_node;
        rd_ptr          <= '0;
        wr_ptr          <= QCNT_BITS'(1);
        bott[src_node]  <= BOT_BITS'(1) << CAP_BITS;
      end
      if (cmd.pop) begin
        cur_x   <= q_head;
        cur_arc <= lh_rd;
        rd_ptr  <= rd_ptr + QCNT_BITS'(1);
      end
      if (cmd.arc_ev) begin
        cur_arc <= link_rdata;
        if (take) begin
          visited[y] <= 1'b1;
          bott[y]    <= b_new;
          arrival[y] <= cur_arc[ARC_BITS-1:0];
          if (wr_ptr < QCNT_BITS'(MAX_NODES)) begin
            queue[wr_ptr[NODE_BITS-1:0]] <= y;
            wr_ptr <= wr_ptr + QCNT_BITS'(1);
          end
        end
        if (sts.found) begin
          push_b <= b_new;
          push_x <= dst_node;
          steps  <= '0;
        end
      end
      if (cmd.push_rd) begin
        push_arc <= arrival[push_x];
      end
      if (cmd.push_rev) begin
        push_x <= tgt_rdata;
        steps  <= steps + QCNT_BITS'(1);
      end
      if (cmd.flow_add) begin
        flow <= (flow_sum > (FLOW_BITS+1)'(FLOW_MAX)) ? FLOW_BITS'(FLOW_MAX)
                                                       : flow_sum[FLOW_BITS-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_data  <= OUT_DATA_W'({drop, flow});
        arc_count <= '0;
        flow      <= '0;
        drop      <= 1'b0;
        for (int n = 0; n < MAX_NODES; n++) begin
          list_head[n] <= PTR_BITS'(MAX_ARCS);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/max_flow_augmenting_path.sv
// Usage: edges arrive on the slave stream, tuser = command (0 add edge, 1 compute).
// Add: tdata carries from_node, to_node, capacity; no result. An edge that does
// not fit the 64-arc store is dropped and flagged until the next compute.
// Compute: runs breadth-first searches and pushes each path's bottleneck until
// the sink is unreachable, then presents one transfer on the master stream
// (max_flow, edges_dropped) and clears the graph.
// Sequence: an edge add steps through the load, forward-arc and reverse-arc states; a dropped
// edge stops after the first two. A compute alternates searches and path pushes, paced by the
// single read port of the arc RAMs; no item is taken meanwhile.
// The result sits in an output register; a stalled receiver holds it there
// while further edge adds are taken, and a following compute waits at its end
// until the register is free.
// Reset (rst, synchronous) empties the graph, clears the total and the drop
// flag, sets source_node 0 and sink_node 1. Configuration via cfg_we,
// cfg_addr (0 source, 1 sink), cfg_data, only while idle.
// Depends on mf_pkg, mf_ctrl, mf_datapath, mf_ram and the defines header.
`default_nettype none
`include "max_flow_augmenting_path_defines.svh"
module max_flow_augmenting_path (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire mf_pkg::cfg_addr_t             cfg_addr,
  input  wire logic [mf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // [3:0] from_node, [7:4] to_node, [23:8] capacity
  input  wire logic [mf_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] command
  input  wire logic                          s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // [20:0] max_flow, [21] edges_dropped, [23:22] zero
  output      logic [mf_pkg::OUT_DATA_W-1:0] m_tdata
);
  import mf_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  ctrl_state_t state;

  mf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_command(s_tuser),
    .in_ready(s_tready), .sts(sts), .cmd(cmd), .state(state)
  );

  mf_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_data(s_tdata), .cmd(cmd), .sts(sts), .out_valid(m_tvalid),
    .out_ready(m_tready), .out_data(m_tdata)
  );

  `MF_ASSERT_SAME(a_arc_bound, 1'b1, sts.arc_cnt <= PTR_BITS'(MAX_ARCS), "arc count overrun")
  `MF_ASSERT_NEXT(a_compute_busy, s_tvalid && s_tready && s_tuser == CMD_COMPUTE, !s_tready, "compute did not hold off input")
  `MF_ASSERT_NEXT(a_emit_source, !m_tvalid && !(state == S_EMIT), !m_tvalid, "result without emit")
  `MF_ASSERT_SAME(a_arc_even, 1'b1, !sts.arc_cnt[0], "arc count odd")
endmodule
`default_nettype wire

FILE: tb/sv/max_flow_augmenting_path_tb.sv
// Self-checking bench for the max-flow block: streams edge loads and compute commands,
// predicts each total with a breadth-first augmenting-path model and checks every transfer.
// Depends on mf_pkg and max_flow_augmenting_path.
`default_nettype none
module max_flow_augmenting_path_tb;
  import mf_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int ARCS_END = MAX_ARCS;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  tail;
    logic [3:0]  head;
    logic [15:0] cap;
  } edge_item_t;

  typedef struct packed {
    logic        chk;
    logic        dropped;
    logic [20:0] flow;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_addr_t cfg_addr = REG_SOURCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  max_flow_augmenting_path dut (.*);

  always #1 clk = ~clk;

  // predictor state
  int unsigned src_node = 0, snk_node = 1;
  int unsigned head_of[MAX_NODES];
  int unsigned tgt[MAX_ARCS], lnk[MAX_ARCS];
  longint unsigned resid[MAX_ARCS];
  int unsigned n_arcs, total;
  bit dropped_edge;
  bit seen[MAX_NODES];
  longint unsigned bneck[MAX_NODES];
  int unsigned via[MAX_NODES], bfsq[MAX_NODES];

  flow_result_t flow_expected[$];
  int unsigned cycles = 0;
  bit failed = 0;
  bit no_idle = 0;

  function automatic void graph_clear();
    foreach (head_of[n]) head_of[n] = ARCS_END;
    n_arcs = 0;
    total = 0;
    dropped_edge = 0;
  endfunction

  function automatic void arc_link(int unsigned a, int unsigned t, int unsigned h,
                                   longint unsigned r);
    tgt[a] = h;
    resid[a] = r;
    lnk[a] = head_of[t];
    head_of[t] = a;
  endfunction

  function automatic bit bfs_reaches(int unsigned s, int unsigned d);
    int unsigned rd, wr, x, a, y;
    longint unsigned b;
    rd = 0;
    wr = 0;
    foreach (seen[n]) seen[n] = 0;
    bfsq[wr++] = s;
    seen[s] = 1;
    bneck[s] = 64'd1 << CAP_BITS;
    while (rd < wr) begin
      x = bfsq[rd++];
      a = head_of[x];
      while (a < n_arcs) begin
        if (resid[a] != 0) begin
          y = tgt[a] % MAX_NODES;
          if (!seen[y]) begin
            b = bneck[x];
            if (resid[a] < b) b = resid[a];
            bneck[y] = b;
            via[y] = a;
            seen[y] = 1;
            if (wr < MAX_NODES) bfsq[wr++] = y;
            if (y == d) return 1;
          end
        end
        a = lnk[a];
      end
    end
    return 0;
  endfunction

  function automatic void augment(int unsigned s, int unsigned d);
    longint unsigned b;
    int unsigned x, a, steps;
    b = bneck[d];
    x = d;
    steps = 0;
    while (x != s && steps < MAX_NODES) begin
      a = via[x];
      if (a >= n_arcs) break;
      resid[a] -= b;
      resid[a ^ 1] += b;
      x = tgt[a ^ 1] % MAX_NODES;
      steps++;
    end
    if (longint'(total) + b > FLOW_MAX) total = FLOW_MAX;
    else total += int'(b);
  endfunction

  function automatic void predict_flow(edge_item_t it);
    flow_result_t r;
    if (it.cmd == CMD_ADD_EDGE) begin
      if (n_arcs + 2 > MAX_ARCS) dropped_edge = 1;
      else begin
        arc_link(n_arcs, it.tail, it.head, it.cap);
        arc_link(n_arcs + 1, it.head, it.tail, 0);
        n_arcs += 2;
      end
    end else begin
      while (bfs_reaches(src_node, snk_node)) augment(src_node, snk_node);
      r.chk = 1;
      r.flow = total[20:0];
      r.dropped = dropped_edge;
      flow_expected.push_back(r);
      graph_clear();
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: stall in bursts, check each transfer
  initial begin
    int stall;
    flow_result_t e;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (flow_expected.size() == 0) begin
          $display("%0t: unexpected transfer %h", $realtime, m_tdata);
          failed = 1;
        end else begin
          e = flow_expected.pop_front();
          if (m_tdata[20:0] !== e.flow || m_tdata[21] !== e.dropped
              || m_tdata[23:22] !== 2'b00) begin
            $display("%0t: expected flow %0d drop %0d, actual flow %0d drop %0d",
                     $realtime, e.flow, e.dropped, m_tdata[20:0], m_tdata[21]);
            failed = 1;
          end
        end
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else m_tready <= 1'b1;
    end
  end

  // valid stays high after a transfer until the next item, an idle burst or a drain
  task automatic send(edge_item_t it);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= {it.cap, it.head, it.tail};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_flow(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (flow_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_ends(int unsigned s, int unsigned d);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= REG_SOURCE;
    cfg_data <= s[3:0];
    @(posedge clk);
    cfg_addr <= REG_SINK;
    cfg_data <= d[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    src_node = s;
    snk_node = d;
  endtask

  function automatic edge_item_t edge_of(int unsigned t, int unsigned h, int unsigned c);
    edge_item_t it;
    it.cmd = CMD_ADD_EDGE;
    it.tail = t[3:0];
    it.head = h[3:0];
    it.cap = c[15:0];
    return it;
  endfunction

  function automatic edge_item_t compute_cmd();
    edge_item_t it;
    it = edge_of($urandom, $urandom, $urandom);
    it.cmd = CMD_COMPUTE;
    return it;
  endfunction

  task automatic random_graph(int unsigned n_edges, int unsigned span);
    int unsigned t;
    for (int i = 0; i < n_edges; i++) begin
      t = $urandom_range(0, 3);
      if (t == 0) send(edge_of(src_node, $urandom_range(0, span), $urandom));
      else if (t == 1) send(edge_of($urandom_range(0, span), snk_node, $urandom));
      else send(edge_of($urandom_range(0, span), $urandom_range(0, span),
                        $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 300)));
    end
    send(compute_cmd());
  endtask

  // directed rows: {item, expected result (chk set where typed in)}
  typedef struct packed {
    edge_item_t   item;
    flow_result_t want;
  } row_t;

  row_t rows[] = '{
    '{{CMD_COMPUTE, 4'h0, 4'h0, 16'h0}, {1'b1, 1'b0, 21'd0}},
    '{{CMD_ADD_EDGE, 4'h0, 4'h1, 16'hFFFF}, '0},
    '{{CMD_COMPUTE, 4'hF, 4'hF, 16'hFFFF}, {1'b1, 1'b0, 21'd65535}},
    '{{CMD_ADD_EDGE, 4'h0, 4'h1, 16'h0}, '0},
    '{{CMD_COMPUTE, 4'h0, 4'h0, 16'h0}, {1'b1, 1'b0, 21'd0}},
    '{{CMD_ADD_EDGE, 4'h0, 4'h2, 16'd10}, '0},
    '{{CMD_ADD_EDGE, 4'h2, 4'h1, 16'd7}, '0},
    '{{CMD_ADD_EDGE, 4'h0, 4'h3, 16'd5}, '0},
    '{{CMD_ADD_EDGE, 4'h3, 4'h1, 16'd9}, '0},
    '{{CMD_ADD_EDGE, 4'h2, 4'h3, 16'd4}, '0},
    '{{CMD_ADD_EDGE, 4'h1, 4'h0, 16'd3}, '0},
    '{{CMD_COMPUTE, 4'h0, 4'h0, 16'h0}, {1'b1, 1'b0, 21'd15}},
    '{{CMD_ADD_EDGE, 4'h1, 4'h0, 16'hFFFF}, '0},
    '{{CMD_ADD_EDGE, 4'h5, 4'h5, 16'hFFFF}, '0},
    '{{CMD_COMPUTE, 4'h0, 4'h0, 16'h0}, {1'b1, 1'b0, 21'd0}}
  };

  initial begin
    graph_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send(rows[i].item);
      if (rows[i].want.chk && flow_expected[$] !== rows[i].want) begin
        $display("%0t: row %0d expected %h, predicted %h", $realtime, i,
                 rows[i].want, flow_expected[$]);
        failed = 1;
      end
    end
    // overflow of the arc store, with a total just below saturation
    for (int i = 0; i < 34; i++) send(edge_of(0, 1, 16'hFFFF));
    send(compute_cmd());
    // wider graph: many parallel paths for a large total
    for (int i = 0; i < 32; i++) send(edge_of(0, 1, 16'hFFFF));
    send(compute_cmd());
    set_ends(15, 15);
    send(edge_of(15, 15, 100));
    send(compute_cmd());
    set_ends(15, 0);
    send(edge_of(15, 0, 16'hFFFF));
    send(edge_of(15, 7, 8));
    send(edge_of(7, 0, 16'hFFFF));
    send(compute_cmd());
    drain();
    set_ends(0, 1);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_ends($urandom_range(0, 15), $urandom_range(0, 15));
      for (int g = 0; g < 18; g++) begin
        if ($urandom_range(0, 7) == 0) send(compute_cmd());
        else random_graph($urandom_range(1, $urandom_range(0, 9) == 0 ? 36 : 14),
                          $urandom_range(1, 15));
      end
      if (ph == 2) drain();
    end
    no_idle = 1;
    for (int g = 0; g < 15; g++) random_graph($urandom_range(1, 14), 15);
    drain();
    if (failed || flow_expected.size() != 0) $display("Simulation FAILED");
    else $display("Simulation PASSED");
    $finish;
  end
endmodule
`default_nettype wire
